[design/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants of the mixed radix converter
// Field widths, stream packing, error and opcode values, config register map.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int WORD_W        = 48;  // integer width
  localparam int DIGIT_W       = 8;   // one digit
  localparam int BASE_W        = 9;   // one radix, 2..256
  localparam int COUNT_W       = 3;   // digit_count register
  localparam int IDX_W         = 3;   // digit position
  localparam int ERR_W         = 2;
  localparam int BIT_CNT_W     = 6;   // counts the bits of one word
  localparam int NUM_BASE_REGS = 6;
  localparam int BASE_SEL_W    = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 9;
  localparam int IN_TDATA_W    = 56;  // digit + packed_value, byte padded
  localparam int OUT_TDATA_W   = 56;  // value + digit_index + error, byte padded
  localparam int OUT_PAD_W     = OUT_TDATA_W - WORD_W - IDX_W - ERR_W;

  localparam logic OP_RANK   = 1'b0;
  localparam logic OP_UNRANK = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIGIT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_FIRST  = 3'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd6;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 9'd2;
  localparam logic [BASE_W-1:0]  BASE_MIN    = 9'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX    = 9'd256;

  typedef struct packed {
    logic                  we;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;  // effective digit count
    logic [BASE_W-1:0]  base;   // effective radix of the selected position
  } cfg_view_t;

endpackage

[design/mixed_radix_converter.sv]
// ----------------------------------------------------------------------------
// mixed_radix_converter: bit-serial mixed radix rank / unrank unit
// Rank folds one digit per item into acc = acc*base + digit; unrank splits an
// integer into digits by repeated restoring division, least significant first.
// ----------------------------------------------------------------------------
// Rank: each digit is accepted in S_IDLE and folded in S_MUL; S_RANK_OUT registers the result.
// Unrank: the accept, then division of every digit in S_DIV, then one result per
//   cycle from S_EMIT while the sink is ready. Multiply and divide work one bit per step.
// One item in work at a time; an input is taken while a result waits to drain.
// Reset (rst, synchronous): config back to 6 digits of radix 2, rank cleared,
//   no result pending. No clearing pass.
module mixed_radix_converter #(
  parameter int MAX_DIGITS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [mrc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mrc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // digit[7:0], packed_value[55:8]
  input  logic                               s_axis_tuser,  // op
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mrc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // value[47:0], digit_index[50:48],
                                                            // error[52:51], zero[55:53]
  output logic                               m_axis_tlast   // last
);
  import mrc_pkg::*;

  localparam int SLOT_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_RANK_OUT = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_W - 1);

  logic [2:0]            state;
  logic [WORD_W-1:0]     acc;          // accumulator, also the division shift register
  logic [IDX_W-1:0]      position;
  logic                  digit_fault;
  logic [BASE_W-1:0]     carry;        // serial multiply carry, starts at the digit
  logic [DIGIT_W-1:0]    rem;          // division remainder, always below the base
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [IDX_W-1:0]      div_pos;
  logic [IDX_W-1:0]      emit_pos;
  logic [SLOT_W-1:0]     wr_ptr;
  logic                  range_err;
  logic [DIGIT_W-1:0]    dline [MAX_DIGITS];  // digits in the order they are given out

  logic [WORD_W-1:0]     out_value;
  logic [IDX_W-1:0]      out_idx;
  logic                  out_last;
  logic [ERR_W-1:0]      out_err;

  cfg_wr_t               cfg_wr;
  cfg_view_t             view;
  logic [BASE_SEL_W-1:0] base_sel;

  logic                  in_op;
  logic [DIGIT_W-1:0]    in_digit;
  logic [WORD_W-1:0]     in_value;
  logic                  in_fire;
  logic                  slot_free;
  logic                  out_load;     // a new result enters the output register

  // bit-serial multiply step: one accumulator bit times the base, plus carry
  logic [BASE_W:0]       mul_sum;
  // restoring division step: one dividend bit into the remainder
  logic [BASE_W-1:0]     div_r2;
  logic                  div_ge;
  logic [BASE_W-1:0]     div_diff;
  logic [DIGIT_W-1:0]    rem_next;
  logic [WORD_W-1:0]     quot_next;
  logic [IDX_W:0]        pos_inc;

  assign cfg_wr = '{we: cfg_we, addr: cfg_addr, data: cfg_wdata};

  assign base_sel = (state == S_DIV) ? div_pos : position;

  mrc_cfg_regs #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr      (cfg_wr),
    .base_sel(base_sel),
    .view    (view)
  );

  assign in_op    = s_axis_tuser;
  assign in_digit = s_axis_tdata[DIGIT_W-1:0];
  assign in_value = s_axis_tdata[DIGIT_W +: WORD_W];

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign out_load      = slot_free && (state inside {S_RANK_OUT, S_EMIT});

  assign mul_sum   = {1'b0, carry} + (acc[0] ? {1'b0, view.base} : '0);
  assign div_r2    = {rem, acc[WORD_W-1]};
  assign div_ge    = (div_r2 >= view.base);
  assign div_diff  = div_r2 - view.base;
  assign rem_next  = div_ge ? div_diff[DIGIT_W-1:0] : div_r2[DIGIT_W-1:0];
  assign quot_next = {acc[WORD_W-2:0], div_ge};
  assign pos_inc   = {1'b0, position} + (IDX_W+1)'(1);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      position      <= '0;
      digit_fault   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_op == OP_RANK) begin
              if ({1'b0, in_digit} >= view.base) digit_fault <= 1'b1;
              state <= S_MUL;
            end else begin
              // unrank drops any partial rank
              position    <= '0;
              digit_fault <= 1'b0;
              state       <= S_DIV;
            end
          end
        end
        S_MUL: begin
          if (bit_cnt == LAST_BIT) begin
            if (pos_inc >= {1'b0, view.count}) begin
              state <= S_RANK_OUT;
            end else begin
              position <= pos_inc[IDX_W-1:0];
              state    <= S_IDLE;
            end
          end
        end
        S_RANK_OUT: begin
          if (slot_free) begin
            m_axis_tvalid <= 1'b1;
            position      <= '0;
            digit_fault   <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_DIV: begin
          if (bit_cnt == LAST_BIT && div_pos == '0) state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            m_axis_tvalid <= 1'b1;
            if (emit_pos == '0) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          bit_cnt <= '0;
          if (in_fire) begin
            if (in_op == OP_RANK) begin
              carry <= {1'b0, in_digit};
            end else begin
              acc     <= in_value;
              rem     <= '0;
              div_pos <= view.count - IDX_W'(1);
              wr_ptr  <= '0;
            end
          end
        end
        S_MUL: begin
          acc     <= {mul_sum[0], acc[WORD_W-1:1]};
          carry   <= mul_sum[BASE_W:1];
          bit_cnt <= bit_cnt + BIT_CNT_W'(1);
        end
        S_RANK_OUT: begin
          if (slot_free) begin
            out_value <= acc;
            out_idx   <= '0;
            out_last  <= 1'b1;
            out_err   <= digit_fault ? ERR_DIGIT : ERR_NONE;
            acc       <= '0;
          end
        end
        S_DIV: begin
          if (bit_cnt == LAST_BIT) begin
            dline[wr_ptr] <= rem_next;
            wr_ptr        <= wr_ptr + SLOT_W'(1);
            rem           <= '0;
            bit_cnt       <= '0;
            if (div_pos == '0) begin
              // quotient left over after all positions means out of range
              range_err <= |quot_next;
              acc       <= '0;
              emit_pos  <= view.count - IDX_W'(1);
            end else begin
              acc     <= quot_next;
              div_pos <= div_pos - IDX_W'(1);
            end
          end else begin
            acc     <= quot_next;
            rem     <= rem_next;
            bit_cnt <= bit_cnt + BIT_CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_value <= WORD_W'(dline[0]);
            out_idx   <= emit_pos;
            out_last  <= (emit_pos == '0);
            out_err   <= range_err ? ERR_RANGE : ERR_NONE;
            emit_pos  <= emit_pos - IDX_W'(1);
            for (int i = 0; i < MAX_DIGITS - 1; i++) dline[i] <= dline[i+1];
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_err, out_idx, out_value};
  assign m_axis_tlast = out_last;

endmodule

[design/mrc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mrc_cfg_regs: configuration registers of the mixed radix converter
// Holds digit_count and the six radices, clamps them to their legal ranges.
// ----------------------------------------------------------------------------
module mrc_cfg_regs #(
  parameter int MAX_DIGITS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mrc_pkg::cfg_wr_t                 wr,
  input  logic [mrc_pkg::BASE_SEL_W-1:0]   base_sel,
  output mrc_pkg::cfg_view_t               view
);
  import mrc_pkg::*;

  logic [COUNT_W-1:0]    digit_count;
  logic [BASE_W-1:0]     base_reg [NUM_BASE_REGS];
  logic [CFG_ADDR_W-1:0] base_addr;
  logic [BASE_W-1:0]     raw_base;

  assign base_addr = wr.addr - REG_BASE_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_RESET;
      for (int i = 0; i < NUM_BASE_REGS; i++) base_reg[i] <= BASE_RESET;
    end else if (wr.we) begin
      if (wr.addr == REG_DIGIT_COUNT) begin
        digit_count <= wr.data[COUNT_W-1:0];
      end else if (wr.addr >= REG_BASE_FIRST &&
                   wr.addr <= CFG_ADDR_W'(NUM_BASE_REGS)) begin
        base_reg[base_addr[BASE_SEL_W-1:0]] <= wr.data[BASE_W-1:0];
      end
    end
  end

  always_comb begin
    // count: zero acts as one, above the digit limit acts as the limit
    if (digit_count == '0)
      view.count = COUNT_W'(1);
    else if (digit_count > COUNT_W'(MAX_DIGITS))
      view.count = COUNT_W'(MAX_DIGITS);
    else
      view.count = digit_count;

    raw_base = (base_sel < BASE_SEL_W'(NUM_BASE_REGS)) ? base_reg[base_sel] : BASE_MIN;
    if (raw_base < BASE_MIN)
      view.base = BASE_MIN;
    else if (raw_base > BASE_MAX)
      view.base = BASE_MAX;
    else
      view.base = raw_base;
  end

endmodule

[design/mrc_checker.sv]
// ----------------------------------------------------------------------------
// mrc_checker: port-level checks of the mixed radix converter
// Watches the stream ports over time; bound to every converter instance.
// ----------------------------------------------------------------------------
module mrc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import mrc_pkg::*;

  logic [ERR_W-1:0] res_err;
  assign res_err = m_axis_tdata[WORD_W+IDX_W +: ERR_W];

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous one still in work");

  a_digit_err_rank_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> res_err != ERR_DIGIT)
    else $error("digit error on a non-final unrank result");

  a_digit_narrow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[WORD_W-1:DIGIT_W] == '0)
    else $error("unranked digit wider than a digit");

endmodule

bind mixed_radix_converter mrc_checker u_mrc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

[bench/tb_mixed_radix_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mixed_radix_converter: self-checking bench for the mixed radix converter
// Drives rank digits and unrank integers over the input stream with random
// gaps and sink stalls, predicts every result item in a scoreboard and checks
// them in order. Config changes happen between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_mixed_radix_converter;
  import mrc_pkg::*;

  localparam int MAX_DIGITS    = 6;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 120;      // room for a rank digit to finish folding in
  localparam int TAIL_CYCLES   = 400;      // longer than a six digit unrank
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int RAND_PHASES   = 8;
  localparam int RAND_ITEMS    = 480;

  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;  // no register here

  typedef struct {
    logic [WORD_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              last;
    logic [ERR_W-1:0]  err;
  } conv_out_t;

  // Tracks the register file and the partial rank, and queues the result
  // items that each accepted input item must produce.
  class radix_checker;
    logic [COUNT_W-1:0] count_reg;
    logic [BASE_W-1:0]  base_reg[NUM_BASE_REGS];
    logic [WORD_W-1:0]  acc;
    logic [IDX_W-1:0]   pos;
    logic               fault;
    conv_out_t          due_outputs[$];
    int                 errors;

    function new();
      count_reg = COUNT_RESET;
      foreach (base_reg[i]) base_reg[i] = BASE_RESET;
      acc    = '0;
      pos    = '0;
      fault  = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DIGIT_COUNT)
        count_reg = data[COUNT_W-1:0];
      else if (idx >= REG_BASE_FIRST && idx < REG_BASE_FIRST + NUM_BASE_REGS)
        base_reg[idx - REG_BASE_FIRST] = data[BASE_W-1:0];
    endfunction

    function int unsigned active_digits();
      int unsigned n;
      n = 32'(count_reg);
      if (n < 1) n = 1;
      if (n > MAX_DIGITS) n = MAX_DIGITS;
      return n;
    endfunction

    // radix clamped to 2..256
    function logic [BASE_W-1:0] radix_of(int p);
      logic [BASE_W-1:0] b;
      b = base_reg[p];
      if (b < BASE_MIN) b = BASE_MIN;
      if (b > BASE_MAX) b = BASE_MAX;
      return b;
    endfunction

    // at most 2^48, so it needs more than a word
    function logic [63:0] radix_product();
      logic [63:0] prod;
      prod = 64'd1;
      for (int i = 0; i < active_digits(); i++) prod = prod * radix_of(i);
      return prod;
    endfunction

    function void take_item(logic op, logic [DIGIT_W-1:0] d, logic [WORD_W-1:0] v);
      int unsigned n;
      logic [63:0] b;
      logic [63:0] wide;
      logic [63:0] prod;
      logic [63:0] rest;
      conv_out_t   r;
      n = active_digits();
      if (op == OP_RANK) begin
        b = 64'(radix_of(int'(pos)));
        if (d >= b) fault = 1'b1;
        wide = {16'd0, acc} * b + d;
        acc  = wide[WORD_W-1:0];
        // completes against the count in force now, even if it moved mid-rank
        if (pos + 1 >= n) begin
          r.value = acc;
          r.index = '0;
          r.last  = 1'b1;
          r.err   = fault ? ERR_DIGIT : ERR_NONE;
          due_outputs.push_back(r);
          acc   = '0;
          pos   = '0;
          fault = 1'b0;
        end else begin
          pos = pos + 1'b1;
        end
      end else begin
        // unrank drops any partial rank
        acc   = '0;
        pos   = '0;
        fault = 1'b0;
        prod  = radix_product();
        rest  = {16'd0, v};
        for (int p = n - 1; p >= 0; p--) begin
          b       = 64'(radix_of(p));
          wide    = rest % b;
          r.value = wide[WORD_W-1:0];
          r.index = p[IDX_W-1:0];
          r.last  = (p == 0);
          r.err   = ({16'd0, v} >= prod) ? ERR_RANGE : ERR_NONE;
          due_outputs.push_back(r);
          rest = rest / b;
        end
      end
    endfunction

    function void check_output(logic [WORD_W-1:0] v, logic [IDX_W-1:0] idx, logic last,
                               logic [ERR_W-1:0] err, logic [OUT_PAD_W-1:0] pad);
      conv_out_t want;
      if (due_outputs.size() == 0) begin
        $display("%0t: unexpected result: value %h index %0d last %0b error %0d",
                 $time, v, idx, last, err);
        errors++;
        return;
      end
      want = due_outputs.pop_front();
      if (v !== want.value) begin
        $display("%0t: value expected %h actual %h", $time, want.value, v);
        errors++;
      end
      if (idx !== want.index) begin
        $display("%0t: digit_index expected %0d actual %0d", $time, want.index, idx);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
      if (err !== want.err) begin
        $display("%0t: error expected %0d actual %0d", $time, want.err, err);
        errors++;
      end
      if (pad !== '0) begin
        $display("%0t: pad bits expected 0 actual %h", $time, pad);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // digit[7:0], packed_value[55:8]
  logic                   s_axis_tuser = 1'b0; // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // value[47:0], digit_index[50:48],
                                         // error[52:51], zero[55:53]
  logic                   m_axis_tlast;

  radix_checker mrc_check = new();
  int           cycles = 0;
  int           items_sent = 0;
  bit           feed_burst = 1'b0;   // no gaps between input items
  bit           drain_burst = 1'b0;  // sink never stalls

  mixed_radix_converter #(.MAX_DIGITS(MAX_DIGITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[WORD_W-1:0];
  endfunction

  // Inputs change on the falling edge; the handshake is seen on the rising one.
  // tvalid is left high on return so a back-to-back item needs no toggle.
  task automatic send_item(input logic op, input logic [DIGIT_W-1:0] d,
                           input logic [WORD_W-1:0] v);
    int gap;
    gap = feed_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {v, d};
    do @(posedge clk); while (!s_axis_tready);
    mrc_check.take_item(op, d, v);
    items_sent++;
    @(negedge clk);
  endtask

  // all results in, then room for a digit still folding in
  task automatic drain_and_settle();
    s_axis_tvalid = 1'b0;
    while (mrc_check.due_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    @(posedge clk);
    mrc_check.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd6;
      3:       return 9'd7;
      default: return 9'($urandom_range(2, 5));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_base();
    case ($urandom_range(0, 7))
      0:       return 9'($urandom_range(0, 1));
      1:       return BASE_MIN;
      2:       return BASE_MAX;
      3:       return 9'($urandom_range(257, 511));
      4:       return 9'($urandom_range(3, 9));
      default: return 9'($urandom_range(3, 255));
    endcase
  endfunction

  task automatic random_config();
    write_cfg(REG_DIGIT_COUNT, pick_count());
    for (int i = 0; i < NUM_BASE_REGS; i++)
      write_cfg(CFG_ADDR_W'(REG_BASE_FIRST + i), pick_base());
    if ($urandom_range(0, 2) == 0) write_cfg(REG_UNMAPPED, 9'($urandom));
  endtask

  // digits still owed before the pending rank completes
  function automatic int rank_left();
    int n;
    int p;
    n = mrc_check.active_digits();
    p = int'(mrc_check.pos);
    return (p + 1 >= n) ? 1 : n - p;
  endfunction

  task automatic rank_digits(input int k);
    logic [BASE_W-1:0]  b;
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < k; i++) begin
      b = mrc_check.radix_of(int'(mrc_check.pos));
      case ($urandom_range(0, 19))
        0:       d = 8'hFF;
        1:       d = 8'(b - 1);
        2, 3:    d = 8'($urandom_range(0, 255));   // may be out of range
        default: d = 8'($urandom_range(0, b - 1));
      endcase
      send_item(OP_RANK, d, rand_word());
    end
  endtask

  task automatic unrank_value();
    logic [63:0] prod;
    logic [63:0] v;
    prod = mrc_check.radix_product();
    case ($urandom_range(0, 9))
      0:       v = 64'hFFFF_FFFF_FFFF;
      1:       v = prod - 1;
      2:       v = (prod < 64'h1_0000_0000_0000) ? prod : {16'd0, rand_word()};
      3, 4:    v = {16'd0, rand_word()};
      default: v = {16'd0, rand_word()} % prod;
    endcase
    send_item(OP_UNRANK, 8'($urandom), v[WORD_W-1:0]);
  endtask

  // result side: random stall before each item, sampled on the rising edge
  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = drain_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      mrc_check.check_output(m_axis_tdata[WORD_W-1:0],
                             m_axis_tdata[WORD_W +: IDX_W],
                             m_axis_tlast,
                             m_axis_tdata[WORD_W+IDX_W +: ERR_W],
                             m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
      @(negedge clk);
    end
  end

  initial begin
    int start;
    int pick;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // reset config: six binary digits
    send_item(OP_RANK, 8'd1, rand_word());
    send_item(OP_RANK, 8'd0, rand_word());
    send_item(OP_RANK, 8'd1, rand_word());
    send_item(OP_RANK, 8'd1, rand_word());
    send_item(OP_RANK, 8'd0, rand_word());
    send_item(OP_RANK, 8'd1, rand_word());
    send_item(OP_UNRANK, 8'hFF, 48'd64);                 // equals the product: just out of range
    send_item(OP_UNRANK, 8'h00, 48'hFFFF_FFFF_FFFF);
    send_item(OP_RANK, 8'd1, rand_word());               // left open across config
    send_item(OP_RANK, 8'd1, rand_word());

    // all radices 256, count 7 clamps to 6: product is exactly 2^48
    drain_and_settle();
    write_cfg(REG_DIGIT_COUNT, 9'd7);
    for (int i = 0; i < NUM_BASE_REGS; i++)
      write_cfg(CFG_ADDR_W'(REG_BASE_FIRST + i), BASE_MAX);
    repeat (4) send_item(OP_RANK, 8'hFF, rand_word());
    send_item(OP_UNRANK, 8'h55, 48'hFFFF_FFFF_FFFF);
    send_item(OP_RANK, 8'hFF, rand_word());              // open rank, count shrinks next

    // count 0 acts as 1, radices below 2 and above 256 clamp, unmapped write
    drain_and_settle();
    write_cfg(REG_DIGIT_COUNT, 9'd0);
    write_cfg(REG_BASE_FIRST, 9'd0);
    write_cfg(REG_BASE_FIRST + 3'd1, 9'd1);
    write_cfg(REG_BASE_FIRST + 3'd2, 9'd511);
    write_cfg(REG_UNMAPPED, 9'h1AA);
    send_item(OP_RANK, 8'd1, rand_word());               // closes the open rank
    send_item(OP_RANK, 8'd1, rand_word());
    send_item(OP_RANK, 8'd2, rand_word());               // digit not below radix
    send_item(OP_UNRANK, 8'd0, 48'd1);
    send_item(OP_UNRANK, 8'd0, 48'd2);                   // too large for radix 2

    // random phases: mostly complete ranks and in-range unranks
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_and_settle();
      random_config();
      feed_burst  = ($urandom_range(0, 3) == 0);
      drain_burst = ($urandom_range(0, 3) == 0);
      start = items_sent;
      while (items_sent - start < RAND_ITEMS / RAND_PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          rank_digits(rank_left());
        end else if (pick < 85) begin
          unrank_value();
        end else if (pick < 95) begin
          // rank cut short by an unrank
          if (rank_left() > 1) rank_digits($urandom_range(1, rank_left() - 1));
          unrank_value();
        end else begin
          send_item(1'($urandom), 8'($urandom), rand_word());
        end
      end
      // sometimes carry a partial rank into the next config
      if ($urandom_range(0, 1) == 0 && rank_left() > 1)
        rank_digits($urandom_range(1, rank_left() - 1));
    end

    s_axis_tvalid = 1'b0;
    while (mrc_check.due_outputs.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mrc_check.errors == 0 && mrc_check.due_outputs.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
